// ===== src/fpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpfm_pkg
// Shared types and constants of the frame peak follower meter: request
// structs for both channels, register codes and fixed-point constants.
// ----------------------------------------------------------------------------
package fpfm_pkg;

    // default width of one pcm sample
    localparam int SAMPLE_WIDTH_DEF = 16;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 15;
    localparam int AMP_W    = 16;
    localparam int CFG_W    = 2;

    // sample_bytes register codes
    localparam logic [CFG_W-1:0] SAMPLE_BYTES_ONE = 2'd1;
    localparam logic [CFG_W-1:0] SAMPLE_BYTES_RST = 2'd2;

    // decay by 3/5: level * 3 * ceil(2^18 / 5) >> 18, exact for 16-bit values
    localparam logic [17:0] DECAY_MUL   = 18'd157287;
    localparam int          DECAY_SHIFT = 18;

    // fourth root of level * 2^49 gives Q0.16 of (level / 32768)^(1/4)
    localparam int ROOT_BITS  = 16;
    localparam int ROOT_SHIFT = PROD_W - LEVEL_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_BITS);

    // amplitude floor of 0.1 in Q0.16
    localparam logic [AMP_W-1:0] AMP_FLOOR = 16'd6554;

    // input request: one sample and its frame end mark
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       frame_end;
    } t_in_req;

    // output request: one result per frame
    typedef struct packed {
        logic [AMP_W-1:0]   amplitude;
        logic [LEVEL_W-1:0] follower_level;
    } t_out_req;

endpackage

// ===== src/fpfm_mul.sv =====
// ----------------------------------------------------------------------------
// fpfm_mul
// Shared unsigned multiplier with a registered product, used for the decay
// scaling and for the squarings of the fourth root search.
// ----------------------------------------------------------------------------
module fpfm_mul (
    input  logic                        i_clk,
    input  logic [fpfm_pkg::MUL_W-1:0]  i_op_a,
    input  logic [fpfm_pkg::MUL_W-1:0]  i_op_b,
    output logic [fpfm_pkg::PROD_W-1:0] o_prod
);
    import fpfm_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    // full-width product
    always_comb begin
        n_prod = PROD_W'(i_op_a) * PROD_W'(i_op_b);
    end

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ===== src/frame_peak_follower_meter.sv =====
// ----------------------------------------------------------------------------
// frame_peak_follower_meter
// Tracks the frame maximum of pcm samples, runs a peak follower at each frame
// end and reports the fourth root of the level as a Q0.16 amplitude.
// ----------------------------------------------------------------------------
// A sample without the frame end mark is taken and ready stays high. A sample
// with the frame end mark starts the frame update: a decay step (only when
// the level falls) and a bit-by-bit fourth root search of 16 steps (square,
// square again, compare), all on one shared 32x32 multiplier; ready returns
// once the result is loaded, after any wait for the output register to free
// up. The result sits in an output register, so ordinary samples of the next
// frame are taken while it waits.
// ----------------------------------------------------------------------------
module frame_peak_follower_meter #(
    parameter int SAMPLE_WIDTH = fpfm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  fpfm_pkg::t_in_req          i_in_req,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output fpfm_pkg::t_out_req         o_out_req,
    // configuration
    input  logic                       i_cfg_wen,
    input  logic [fpfm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import fpfm_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECAY     = 3'd1;
    localparam logic [2:0] S_DECAY_WB  = 3'd2;
    localparam logic [2:0] S_ROOT_SQ   = 3'd3;
    localparam logic [2:0] S_ROOT_QUAD = 3'd4;
    localparam logic [2:0] S_ROOT_CMP  = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [CFG_W-1:0]      r_sample_bytes;
    logic [LEVEL_W-1:0]    r_frame_peak, n_frame_peak;
    logic [LEVEL_W-1:0]    r_prev_peak, n_prev_peak;
    logic [LEVEL_W-1:0]    r_held, n_held;
    logic [AMP_W-1:0]      r_root, n_root;
    logic [ROOT_CNT_W-1:0] r_bit, n_bit;
    logic                  r_out_valid, n_out_valid;
    t_out_req              r_out_req, n_out_req;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [LEVEL_W-1:0]    w_pos;
    logic [LEVEL_W-1:0]    w_cur_max;
    logic [LEVEL_W-1:0]    w_peak;
    logic [AMP_W-1:0]      w_trial;
    logic [MUL_W-1:0]      w_op_a, w_op_b;
    logic [PROD_W-1:0]     w_prod;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // positive part of the sample, zero when negative
    always_comb begin
        if (r_sample_bytes == SAMPLE_BYTES_ONE) begin
            w_pos = i_in_req.sample_value[7] ? '0
                                             : LEVEL_W'(i_in_req.sample_value[6:0]);
        end else begin
            w_pos = i_in_req.sample_value[SAMPLE_WIDTH-1] ? '0
                    : LEVEL_W'(i_in_req.sample_value[SAMPLE_WIDTH-2:0]);
        end
    end

    // frame maximum including this sample, silent frame falls back
    assign w_cur_max = (w_pos > r_frame_peak) ? w_pos : r_frame_peak;
    assign w_peak    = (w_cur_max == '0) ? r_prev_peak : w_cur_max;

    // trial root with the current bit set
    assign w_trial = r_root | (AMP_W'(1) << r_bit);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_DECAY: begin
                w_op_a = MUL_W'(r_held);
                w_op_b = MUL_W'(DECAY_MUL);
            end
            S_ROOT_SQ: begin
                w_op_a = MUL_W'(w_trial);
                w_op_b = MUL_W'(w_trial);
            end
            S_ROOT_QUAD: begin
                w_op_a = w_prod[MUL_W-1:0];
                w_op_b = w_prod[MUL_W-1:0];
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    fpfm_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_frame_peak = r_frame_peak;
        n_prev_peak  = r_prev_peak;
        n_held       = r_held;
        n_root       = r_root;
        n_bit        = r_bit;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_req    = r_out_req;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_req.frame_end) begin
                        n_frame_peak = '0;
                        n_prev_peak  = w_peak;
                        n_root       = '0;
                        n_bit        = ROOT_CNT_W'(ROOT_BITS - 1);
                        if (w_peak >= r_held) begin
                            n_held  = w_peak;
                            n_state = S_ROOT_SQ;
                        end else begin
                            n_state = S_DECAY;
                        end
                    end else begin
                        n_frame_peak = w_cur_max;
                    end
                end
            end
            S_DECAY: begin
                n_state = S_DECAY_WB;
            end
            S_DECAY_WB: begin
                n_held  = w_prod[DECAY_SHIFT+LEVEL_W-1:DECAY_SHIFT];
                n_state = S_ROOT_SQ;
            end
            S_ROOT_SQ: begin
                n_state = S_ROOT_QUAD;
            end
            S_ROOT_QUAD: begin
                n_state = S_ROOT_CMP;
            end
            S_ROOT_CMP: begin
                if (w_prod <= {r_held, {ROOT_SHIFT{1'b0}}}) begin
                    n_root = w_trial;
                end
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_ROOT_SQ;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid               = 1'b1;
                    n_out_req.amplitude       = (r_root < AMP_FLOOR) ? AMP_FLOOR : r_root;
                    n_out_req.follower_level  = r_held;
                    n_state                   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_bytes <= SAMPLE_BYTES_RST;
            r_frame_peak   <= '0;
            r_prev_peak    <= '0;
            r_held         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_frame_peak <= n_frame_peak;
            r_prev_peak  <= n_prev_peak;
            r_held       <= n_held;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wen) begin
                r_sample_bytes <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_out_req <= n_out_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // a frame end blocks new samples while the update runs
    a_frame_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_req.frame_end) |=> !o_in_ready)
        else $error("frame end did not start the update");

    // frame maximum restarts after each frame end
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_req.frame_end) |=> (r_frame_peak == '0))
        else $error("frame maximum not cleared");

    // finishing the update presents the level just computed
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=>
            (o_out_valid && o_out_req.follower_level == $past(r_held)))
        else $error("result not loaded on completion");

    // amplitude never below the floor
    a_amp_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.amplitude >= AMP_FLOOR))
        else $error("amplitude below floor");

endmodule
